// ===== sv/metropolis_site_update_macros.svh =====
// Assertion macros for the Metropolis site update block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef METROPOLIS_SITE_UPDATE_MACROS_SVH
`define METROPOLIS_SITE_UPDATE_MACROS_SVH

// condition holds on every edge out of reset
`define MSU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds at the next edge after the antecedent
`define MSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/msu_pkg.sv =====
// Shared types, constants and helpers for the Metropolis site update block.
// No dependencies.
`timescale 1ns / 1ps

package msu_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 24;
    localparam int TABLE_DEPTH = 256;

    localparam logic [31:0] HASH_GOLDEN  = 32'h9E37_79B9;
    localparam logic [31:0] HASH_SEEDMUL = 32'h85EB_CA6B;
    localparam logic [31:0] HASH_MUL_A   = 32'h7FEB_352D;
    localparam logic [31:0] HASH_MUL_B   = 32'h846C_A68B;
    localparam logic [7:0]  TABLE_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        REG_USE_HASH = 2'd0,
        REG_SEED     = 2'd1,
        REG_SWEEP    = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_SITE_UPDATE = 1'b1
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [7:0]      center;
        logic [5:0][7:0] nbr;
        logic [31:0]     index;
        logic [7:0]      step;
        logic [7:0]      chance;
    } site_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] center;
        logic [7:0] nv;
        logic [7:0] step;
        logic [7:0] chance;
        logic [9:0] sum_old;
        logic [9:0] sum_new;
    } action_t;

    typedef struct packed {
        logic [7:0]        center;
        logic [7:0]        nv;
        logic [7:0]        chance;
        logic signed [10:0] ds;
        logic              pos;
    } decide_t;

    function automatic logic [7:0] ring_distance(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        logic [8:0] e;
        d = a - b;
        e = 9'd256 - {1'b0, d};
        return ({1'b0, d} < e) ? d : e[7:0];
    endfunction

endpackage

// ===== sv/msu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/metropolis_site_update.sv =====
// Metropolis update of one Z256 lattice site; depends on msu_pkg, msu_ram and
// metropolis_site_update_macros.svh.
//
// Input stream (s_*): one transfer per item. s_tuser is the op: table write or
// site update. A table write stores chance_value at proposal_step in the
// acceptance table and produces no result. A site update produces exactly one
// result on the output stream (m_*): new value, accept flag, action change.
// Configuration: cfg_we with cfg_addr selects use_hash_random, seed_value or
// sweep_number; write only while no items are in flight.
// Throughput: one item per cycle while the output is not stalled. An item passes
// through six register stages: item capture with the
// configuration products, two hash multiplier stages, the action sum stage,
// the registered read of the table RAM and the output register.
// All stages move together; s_tready = !m_tvalid || m_tready, so a stalled
// receiver holds every stage and the RAM read data in place.
// Reset clears configuration and all valid bits; the table is undefined until
// written and must be loaded before any site update reads an entry.
`timescale 1ns / 1ps
`include "metropolis_site_update_macros.svh"

module metropolis_site_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // center, right, left, up, down, front, back, site_index, proposal_step, chance_value
    input  logic [msu_pkg::IN_TDATA_W-1:0]     s_tdata,
    // op
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_value, accepted, action_change, zero pad
    output logic [msu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_addr,
    input  logic [31:0]                        cfg_wdata
);

    logic        use_hash_reg;
    logic [31:0] seed_reg;
    logic [31:0] sweep_reg;

    logic advance;

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_tvalid_reg;
    msu_pkg::site_t      site_in;
    msu_pkg::site_t      site1_reg, site2_reg, site3_reg;
    logic [31:0]         mix_sweep1_reg, mix_seed1_reg;
    logic [31:0]         hash2_next, hash2_reg;
    logic [31:0]         hash3_next, hash3_reg;
    msu_pkg::action_t    act4_next, act4_reg;
    msu_pkg::decide_t    dec5_next, dec6_reg;
    logic [7:0]          taddr5;
    logic [7:0]          tdata6;

    logic [7:0]          out_value_next, out_value_reg;
    logic                out_acc_next, out_acc_reg;
    logic signed [10:0]  out_ds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_hash_reg <= 1'b0;
            seed_reg     <= '0;
            sweep_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                msu_pkg::REG_USE_HASH: use_hash_reg <= cfg_wdata[0];
                msu_pkg::REG_SEED:     seed_reg     <= cfg_wdata;
                msu_pkg::REG_SWEEP:    sweep_reg    <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    always_comb
    begin
        site_in.op     = msu_pkg::op_t'(s_tuser);
        site_in.center = s_tdata[7:0];
        site_in.nbr    = s_tdata[55:8];
        site_in.index  = s_tdata[87:56];
        site_in.step   = s_tdata[95:88];
        site_in.chance = s_tdata[103:96];
    end

    // stage 1: capture item, multiply configuration terms
    // stage 2: first mix and multiply
    // stage 3: second multiply
    always_comb
    begin
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] y1;
        x1 = (site1_reg.index + mix_sweep1_reg) ^ mix_seed1_reg;
        x2 = x1 ^ (x1 >> 16);
        hash2_next = x2 * msu_pkg::HASH_MUL_A;
        y1 = hash2_reg ^ (hash2_reg >> 15);
        hash3_next = y1 * msu_pkg::HASH_MUL_B;
    end

    // stage 4: select random source, sum ring distances
    always_comb
    begin
        logic [31:0] h;
        logic        take_hash;
        logic [7:0]  nv;
        logic [9:0]  s_old;
        logic [9:0]  s_new;
        h = hash3_reg ^ (hash3_reg >> 16);
        take_hash = use_hash_reg && (site3_reg.op == msu_pkg::OP_SITE_UPDATE);
        act4_next.op     = site3_reg.op;
        act4_next.center = site3_reg.center;
        act4_next.step   = take_hash ? h[7:0] : site3_reg.step;
        act4_next.chance = take_hash ? h[15:8] : site3_reg.chance;
        nv = site3_reg.center + act4_next.step;
        act4_next.nv = nv;
        s_old = '0;
        s_new = '0;
        for (int n = 0; n < 6; n++)
        begin
            s_old = s_old + {2'b00, msu_pkg::ring_distance(site3_reg.center, site3_reg.nbr[n])};
            s_new = s_new + {2'b00, msu_pkg::ring_distance(nv, site3_reg.nbr[n])};
        end
        act4_next.sum_old = s_old;
        act4_next.sum_new = s_new;
    end

    // stage 5: action change, clamp, table access
    always_comb
    begin
        logic signed [10:0] ds;
        ds = $signed({1'b0, act4_reg.sum_new}) - $signed({1'b0, act4_reg.sum_old});
        dec5_next.center = act4_reg.center;
        dec5_next.nv     = act4_reg.nv;
        dec5_next.chance = act4_reg.chance;
        dec5_next.ds     = ds;
        dec5_next.pos    = !ds[10] && (ds != '0);
        taddr5 = (ds[9:8] != 2'b00) ? msu_pkg::TABLE_MAX : ds[7:0];
    end

    msu_ram #(
        .WIDTH (8),
        .DEPTH (msu_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (advance && v4_reg && (act4_reg.op == msu_pkg::OP_TABLE_WRITE)),
        .waddr (act4_reg.step),
        .wdata (act4_reg.chance),
        .re    (advance && v4_reg && (act4_reg.op == msu_pkg::OP_SITE_UPDATE)),
        .raddr (taddr5),
        .rdata (tdata6)
    );

    // stage 6: accept decision
    always_comb
    begin
        out_acc_next   = !dec6_reg.pos || (dec6_reg.chance < tdata6);
        out_value_next = out_acc_next ? dec6_reg.nv : dec6_reg.center;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg && (act4_reg.op == msu_pkg::OP_SITE_UPDATE);
            m_tvalid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            site1_reg      <= site_in;
            mix_sweep1_reg <= 32'((sweep_reg + 32'd1) * msu_pkg::HASH_GOLDEN);
            mix_seed1_reg  <= 32'(seed_reg * msu_pkg::HASH_SEEDMUL);
            site2_reg      <= site1_reg;
            hash2_reg      <= hash2_next;
            site3_reg      <= site2_reg;
            hash3_reg      <= hash3_next;
            act4_reg       <= act4_next;
            dec6_reg       <= dec5_next;
            out_value_reg  <= out_value_next;
            out_acc_reg    <= out_acc_next;
            out_ds_reg     <= dec6_reg.ds;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_ds_reg, out_acc_reg, out_value_reg};

    `MSU_ASSERT_ALWAYS(a_nonpos_accepts, !(m_tvalid_reg && (out_ds_reg[10] || (out_ds_reg == '0))) || out_acc_reg, "non-positive change rejected")
    `MSU_ASSERT_ALWAYS(a_ds_range, !m_tvalid_reg || ((out_ds_reg >= -11'sd768) && (out_ds_reg <= 11'sd768)), "action change out of range")
    `MSU_ASSERT_NEXT(a_write_no_result, advance && v4_reg && (act4_reg.op == msu_pkg::OP_TABLE_WRITE), !v5_reg, "table write produced a result")

endmodule
